// ----- src/wpd_pkg.sv -----
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the WAV PCM16 parser and mono downmix.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int SAMPLE_W = 16;

  // Chunk tags as they read after four bytes are shifted in little-endian.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [15:0] FMT_BITS_16  = 16'd16;
  localparam logic [31:0] FMT_MIN_LEN  = 32'd16;

  // Byte offsets inside the RIFF header, the chunk header and the fmt body.
  localparam logic [31:0] RIFF_TAG_END  = 32'd3;
  localparam logic [31:0] RIFF_WAVE_END = 32'd11;
  localparam logic [31:0] HDR_TAG_LEN   = 32'd4;
  localparam logic [31:0] HDR_LAST      = 32'd7;
  localparam logic [31:0] FMT_TAG_LO    = 32'd0;
  localparam logic [31:0] FMT_TAG_HI    = 32'd1;
  localparam logic [31:0] FMT_CHAN_LO   = 32'd2;
  localparam logic [31:0] FMT_CHAN_HI   = 32'd3;
  localparam logic [31:0] FMT_RATE_LO   = 32'd4;
  localparam logic [31:0] FMT_RATE_HI   = 32'd7;
  localparam logic [31:0] FMT_BITS_LO   = 32'd14;
  localparam logic [31:0] FMT_BITS_HI   = 32'd15;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE   = 3'd1;
  localparam logic [2:0] ST_BAD_FORMAT = 3'd2;
  localparam logic [2:0] ST_MISSING    = 3'd3;
  localparam logic [2:0] ST_DATA_FIRST = 3'd4;

  localparam logic RK_SAMPLE = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  typedef struct packed {
    logic take_byte;
    logic div_start;
    logic load_sample;
    logic sample_last;
    logic load_status;
  } wpd_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic div_done;
  } wpd_sts_t;

endpackage

// ----- src/wpd_in_if.sv -----
// ----------------------------------------------------------------------------
// wpd_in_if
// Byte channel into the parser: each item carries at most one file byte and may mark the end of the file.
// ----------------------------------------------------------------------------
interface wpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       end_of_file;

  modport source (output valid, output byte_value, output byte_valid,
                  output end_of_file, input ready);
  modport sink   (input valid, input byte_value, input byte_valid,
                  input end_of_file, output ready);
endinterface

// ----- src/wpd_out_if.sv -----
// ----------------------------------------------------------------------------
// wpd_out_if
// Result channel: mono samples and the final file status.
// ----------------------------------------------------------------------------
interface wpd_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic signed [15:0] mono_sample;
  logic [2:0]         status_code;
  logic [31:0]        rate_hz;
  logic [15:0]        channel_count;
  logic               last_of_run;

  modport source (output valid, output result_kind, output mono_sample,
                  output status_code, output rate_hz, output channel_count,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input mono_sample,
                  input status_code, input rate_hz, input channel_count,
                  input last_of_run, output ready);
endinterface

// ----- src/wpd_div.sv -----
// ----------------------------------------------------------------------------
// wpd_div
// Signed-by-unsigned restoring divider, four quotient bits per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wpd_div
  import wpd_pkg::*;
#(
  parameter int SUM_W = 21,
  parameter int DIV_W = 5
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [SUM_W-1:0]    dividend,
  input  logic        [DIV_W-1:0]    divisor,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] quotient
);

  localparam int STEP_BITS = 4;
  localparam int STEPS     = (SUM_W + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W     = STEPS * STEP_BITS;
  localparam int CNT_W     = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             neg_r, neg_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [PAD_W-1:0] dvd_r, dvd_nxt;
  logic [PAD_W-1:0] quo_r, quo_nxt;
  logic [DIV_W:0]   rem_r, rem_nxt;

  logic [DIV_W:0]   rem_v;
  logic [DIV_W:0]   shl_v;
  logic [PAD_W-1:0] dvd_v;
  logic [PAD_W-1:0] quo_v;
  logic [SUM_W-1:0] abs_v;
  logic [SAMPLE_W-1:0] mag;

  always_comb begin
    rem_v = rem_r;
    dvd_v = dvd_r;
    quo_v = quo_r;
    shl_v = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      shl_v = {rem_v[DIV_W-1:0], dvd_v[PAD_W-1]};
      dvd_v = {dvd_v[PAD_W-2:0], 1'b0};
      if (shl_v >= {1'b0, dsr_r}) begin
        rem_v = shl_v - {1'b0, dsr_r};
        quo_v = {quo_v[PAD_W-2:0], 1'b1};
      end else begin
        rem_v = shl_v;
        quo_v = {quo_v[PAD_W-2:0], 1'b0};
      end
    end
  end

  assign abs_v = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS - 1);
      neg_nxt  = dividend[SUM_W-1];
      dsr_nxt  = divisor;
      dvd_nxt  = PAD_W'(abs_v);
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_v;
      quo_nxt = quo_v;
      rem_nxt = rem_v;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign mag      = quo_r[SAMPLE_W-1:0];
  assign quotient = neg_r ? $signed(~mag + 1'b1) : $signed(mag);
  assign done     = done_r;

endmodule

// ----- src/wpd_dpath.sv -----
// ----------------------------------------------------------------------------
// wpd_dpath
// Byte parser registers, frame accumulator, divider and result register.
// ----------------------------------------------------------------------------
module wpd_dpath
  import wpd_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int SUM_W        = 21,
  parameter int DIV_W        = 5,
  parameter int POS_W        = 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wpd_cmd_t                   cmd,
  output wpd_sts_t                   sts,
  input  logic [7:0]                 byte_value,
  output logic                       result_kind,
  output logic signed [SAMPLE_W-1:0] mono_sample,
  output logic [2:0]                 status_code,
  output logic [31:0]                rate_hz,
  output logic [15:0]                channel_count,
  output logic                       last_of_run
);

  typedef enum logic [6:0] {
    PH_RIFF = 7'b000_0001,
    PH_HDR  = 7'b000_0010,
    PH_FMT  = 7'b000_0100,
    PH_DATA = 7'b000_1000,
    PH_SKIP = 7'b001_0000,
    PH_PAD  = 7'b010_0000,
    PH_DONE = 7'b100_0000
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [31:0]              count_r, count_nxt;
  logic [31:0]              len_r, len_nxt;
  logic [31:0]              tag_r, tag_nxt;
  logic [15:0]              ftag_r, ftag_nxt;
  logic [15:0]              chan_r, chan_nxt;
  logic [31:0]              rate_r, rate_nxt;
  logic [15:0]              bits_r, bits_nxt;
  logic                     have_fmt_r, have_fmt_nxt;
  logic                     have_smp_r, have_smp_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [7:0]               low_r, low_nxt;
  logic [2:0]               code_r, code_nxt;

  logic                       okind_r;
  logic signed [SAMPLE_W-1:0] osmp_r;
  logic [2:0]                 ocode_r;
  logic [31:0]                orate_r;
  logic [15:0]                ochan_r;
  logic                       olast_r;

  logic [31:0]              cnt_inc;
  logic [31:0]              tag_shift;
  logic [31:0]              len_shift;
  logic signed [15:0]       raw_smp;
  logic signed [SUM_W-1:0]  sum_add;
  logic                     frame_end;
  logic                     fmt_bad;
  logic [15:0]              ftag_f;
  logic [15:0]              chan_f;
  logic [15:0]              bits_f;
  logic [31:0]              rate_f;
  logic [2:0]               final_code;
  logic signed [SAMPLE_W-1:0] div_q;
  logic                     div_done;

  assign cnt_inc   = count_r + 32'd1;
  assign tag_shift = {byte_value, tag_r[31:8]};
  assign len_shift = {byte_value, len_r[31:8]};
  assign raw_smp   = $signed({byte_value, low_r});
  assign sum_add   = sum_r + SUM_W'(raw_smp);
  assign frame_end = (16'(pos_r) == (chan_r - 16'd1));

  assign sts.frame_done = (phase_r == PH_DATA) && count_r[0] && frame_end;
  assign sts.div_done   = div_done;

  // fmt fields as they stand once the current byte is stored.
  always_comb begin
    ftag_f = ftag_r;
    chan_f = chan_r;
    bits_f = bits_r;
    rate_f = rate_r;
    if (count_r == FMT_TAG_LO) ftag_f = {8'h00, byte_value};
    if (count_r == FMT_TAG_HI) ftag_f = {byte_value, ftag_r[7:0]};
    if (count_r == FMT_CHAN_LO) chan_f = {8'h00, byte_value};
    if (count_r == FMT_CHAN_HI) chan_f = {byte_value, chan_r[7:0]};
    if (count_r >= FMT_RATE_LO && count_r <= FMT_RATE_HI) rate_f = {byte_value, rate_r[31:8]};
    if (count_r == FMT_BITS_LO) bits_f = {8'h00, byte_value};
    if (count_r == FMT_BITS_HI) bits_f = {byte_value, bits_r[7:0]};
  end

  assign fmt_bad = (ftag_f != FMT_PCM) || (bits_f != FMT_BITS_16) ||
                   (chan_f == 16'd0) || (chan_f > 16'(MAX_CHANNELS));

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    len_nxt      = len_r;
    tag_nxt      = tag_r;
    ftag_nxt     = ftag_r;
    chan_nxt     = chan_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    have_fmt_nxt = have_fmt_r;
    have_smp_nxt = have_smp_r;
    sum_nxt      = sum_r;
    pos_nxt      = pos_r;
    low_nxt      = low_r;
    code_nxt     = code_r;

    if (cmd.load_status) begin
      // The file is finished: everything returns to its reset value.
      phase_nxt    = PH_RIFF;
      count_nxt    = '0;
      len_nxt      = '0;
      tag_nxt      = '0;
      ftag_nxt     = '0;
      chan_nxt     = '0;
      rate_nxt     = '0;
      bits_nxt     = '0;
      have_fmt_nxt = 1'b0;
      have_smp_nxt = 1'b0;
      sum_nxt      = '0;
      pos_nxt      = '0;
      low_nxt      = '0;
      code_nxt     = ST_OK;
    end else if (cmd.take_byte) begin
      unique case (phase_r)
        PH_RIFF: begin
          tag_nxt   = tag_shift;
          count_nxt = cnt_inc;
          if (count_r == RIFF_TAG_END && tag_shift != TAG_RIFF) begin
            code_nxt  = ST_NOT_WAVE;
            phase_nxt = PH_DONE;
          end else if (count_r == RIFF_WAVE_END) begin
            if (tag_shift != TAG_WAVE) begin
              code_nxt  = ST_NOT_WAVE;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_HDR;
              count_nxt = '0;
            end
          end
        end
        PH_HDR: begin
          if (count_r < HDR_TAG_LEN) tag_nxt = tag_shift;
          else len_nxt = len_shift;
          count_nxt = cnt_inc;
          if (count_r == HDR_LAST) begin
            count_nxt = '0;
            if (tag_r == TAG_FMT) begin
              // An empty fmt chunk is short at once.
              if (len_shift == '0) begin
                code_nxt  = ST_MISSING;
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_FMT;
              end
            end else if (tag_r == TAG_DATA) begin
              if (!have_fmt_r) begin
                code_nxt  = ST_DATA_FIRST;
                phase_nxt = PH_DONE;
              end else begin
                sum_nxt = '0;
                pos_nxt = '0;
                if (len_shift == '0) begin
                  have_smp_nxt = 1'b1;
                  phase_nxt    = PH_DONE;
                end else begin
                  phase_nxt = PH_DATA;
                end
              end
            end else begin
              phase_nxt = (len_shift == '0) ? PH_HDR : PH_SKIP;
            end
          end
        end
        PH_FMT: begin
          ftag_nxt  = ftag_f;
          chan_nxt  = chan_f;
          bits_nxt  = bits_f;
          rate_nxt  = rate_f;
          count_nxt = cnt_inc;
          if (cnt_inc == len_r) begin
            if (len_r < FMT_MIN_LEN) begin
              code_nxt  = ST_MISSING;
              phase_nxt = PH_DONE;
            end else if (fmt_bad) begin
              have_fmt_nxt = 1'b0;
              code_nxt     = ST_BAD_FORMAT;
              phase_nxt    = PH_DONE;
            end else begin
              have_fmt_nxt = 1'b1;
              phase_nxt    = len_r[0] ? PH_PAD : PH_HDR;
              count_nxt    = '0;
            end
          end
        end
        PH_DATA: begin
          if (!count_r[0]) begin
            low_nxt = byte_value;
          end else if (frame_end) begin
            sum_nxt = '0;
            pos_nxt = '0;
          end else begin
            sum_nxt = sum_add;
            pos_nxt = pos_r + 1'b1;
          end
          count_nxt = cnt_inc;
          if (cnt_inc == len_r) begin
            have_smp_nxt = 1'b1;
            phase_nxt    = PH_DONE;
          end
        end
        PH_SKIP: begin
          count_nxt = cnt_inc;
          if (cnt_inc == len_r) begin
            phase_nxt = len_r[0] ? PH_PAD : PH_HDR;
            count_nxt = '0;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_HDR;
          count_nxt = '0;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_RIFF;
      count_r    <= '0;
      len_r      <= '0;
      tag_r      <= '0;
      ftag_r     <= '0;
      chan_r     <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      have_fmt_r <= 1'b0;
      have_smp_r <= 1'b0;
      sum_r      <= '0;
      pos_r      <= '0;
      low_r      <= '0;
      code_r     <= ST_OK;
    end else begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      len_r      <= len_nxt;
      tag_r      <= tag_nxt;
      ftag_r     <= ftag_nxt;
      chan_r     <= chan_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      have_fmt_r <= have_fmt_nxt;
      have_smp_r <= have_smp_nxt;
      sum_r      <= sum_nxt;
      pos_r      <= pos_nxt;
      low_r      <= low_nxt;
      code_r     <= code_nxt;
    end
  end

  wpd_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_add),
    .divisor  (chan_r[DIV_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign final_code = (code_r != ST_OK) ? code_r :
                      (have_fmt_r && have_smp_r) ? ST_OK : ST_MISSING;

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      okind_r <= RK_SAMPLE;
      osmp_r  <= div_q;
      ocode_r <= ST_OK;
      orate_r <= '0;
      ochan_r <= '0;
      olast_r <= cmd.sample_last;
    end else if (cmd.load_status) begin
      okind_r <= RK_STATUS;
      osmp_r  <= '0;
      ocode_r <= final_code;
      orate_r <= rate_r;
      ochan_r <= chan_r;
      olast_r <= 1'b1;
    end
  end

  assign result_kind   = okind_r;
  assign mono_sample   = osmp_r;
  assign status_code   = ocode_r;
  assign rate_hz       = orate_r;
  assign channel_count = ochan_r;
  assign last_of_run   = olast_r;

endmodule

// ----- src/wpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpd_ctrl
// Sequencer: takes items, runs the divider on frame ends and hands the
// sample and status results to the output register.
// ----------------------------------------------------------------------------
module wpd_ctrl
  import wpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_byte_valid,
  input  logic     in_end_of_file,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output wpd_cmd_t cmd,
  input  wpd_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV    = 4'b0010,
    S_SAMPLE = 4'b0100,
    S_STATUS = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   eof_r, eof_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !ovalid_r || out_ready;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt       = state_r;
    eof_nxt         = eof_r;
    cmd.take_byte   = accept && in_byte_valid;
    cmd.div_start   = 1'b0;
    cmd.load_sample = 1'b0;
    cmd.sample_last = !eof_r;
    cmd.load_status = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          eof_nxt = in_end_of_file;
          if (in_byte_valid && sts.frame_done) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else if (in_end_of_file) begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_SAMPLE;
      end
      S_SAMPLE: begin
        if (out_free) begin
          cmd.load_sample = 1'b1;
          state_nxt       = eof_r ? S_STATUS : S_IDLE;
        end
      end
      S_STATUS: begin
        if (out_free) begin
          cmd.load_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.load_sample || cmd.load_status) ovalid_nxt = 1'b1;
    else if (out_ready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      eof_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      eof_r    <= eof_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ----- src/wav_pcm16_parse_downmix.sv -----
// Timing: a frame-ending byte starts the divider (a 4-bit-per-cycle divider), and
// its sample passes through S_DIV and S_SAMPLE into the output register; an
// end-of-file item gives its status after that sample, or after itself.
// Throughput: one byte per cycle while in S_IDLE; no item is taken while a frame end
// or an end of file is processed, nor while the output register waits on the sink.
// Synchronous reset (rst_n low) restarts the parser and empties the output register.
// ----------------------------------------------------------------------------
// wav_pcm16_parse_downmix
// Streaming RIFF/WAVE PCM16 parser with a channel-average mono downmix.
// ----------------------------------------------------------------------------
module wav_pcm16_parse_downmix
  import wpd_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  wpd_in_if.sink       in_ch,
  wpd_out_if.source    out_ch
);

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_CHANNELS) + 1;
  localparam int DIV_W = $clog2(MAX_CHANNELS + 1);
  localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  wpd_cmd_t cmd;
  wpd_sts_t sts;

  wpd_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_byte_valid  (in_ch.byte_valid),
    .in_end_of_file (in_ch.end_of_file),
    .in_ready       (in_ch.ready),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .cmd            (cmd),
    .sts            (sts)
  );

  wpd_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SUM_W        (SUM_W),
    .DIV_W        (DIV_W),
    .POS_W        (POS_W)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .byte_value    (in_ch.byte_value),
    .result_kind   (out_ch.result_kind),
    .mono_sample   (out_ch.mono_sample),
    .status_code   (out_ch.status_code),
    .rate_hz       (out_ch.rate_hz),
    .channel_count (out_ch.channel_count),
    .last_of_run   (out_ch.last_of_run)
  );

endmodule

// ----- test/wav_pcm16_parse_downmix_test.sv -----
// ----------------------------------------------------------------------------
// wav_pcm16_parse_downmix_test
// Streams WAV byte images through the parser and compares every mono sample
// and status result against a cycle-free parser model kept in the bench.
// ----------------------------------------------------------------------------
module wav_pcm16_parse_downmix_test
  import wpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHANS        = 8;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int DRAIN_CYCLES     = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS     = 150;
  localparam int MAX_REPORTS      = 40;

  typedef enum logic [2:0] {
    IN_RIFF, IN_HEADER, IN_FMT, IN_DATA, IN_SKIP, IN_PAD, IN_DONE
  } walk_phase_t;

  typedef struct {
    logic               kind;
    logic signed [15:0] mono;
    logic [2:0]         status;
    logic [31:0]        rate;
    logic [15:0]        chans;
    logic               last;
  } wav_output_t;

  logic clk;
  logic rst_n;

  wpd_in_if  in_ch();
  wpd_out_if out_ch();

  wav_pcm16_parse_downmix #(.MAX_CHANNELS(MAX_CHANS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Parser state mirrored from the accepted items.
  walk_phase_t walk_phase;
  logic [31:0] region_count;
  logic [31:0] chunk_len;
  logic [31:0] tag_shift;
  logic [15:0] fmt_code;
  logic [15:0] fmt_chans;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_bits;
  logic        fmt_valid;
  logic        data_complete;
  int          frame_acc;
  int          frame_chan;
  logic [7:0]  held_low;
  logic [2:0]  latched_status;

  wav_output_t pending_outputs[$];
  logic [7:0]  wav_bytes[$];

  int  error_count;
  int  items_sent;
  int  files_sent;
  int  samples_checked;
  int  statuses_checked;
  int  cycle_count;
  int  hold_requests;
  int  hold_served;
  bit  sender_eager;

  function automatic void clear_parser();
    walk_phase     = IN_RIFF;
    region_count   = '0;
    chunk_len      = '0;
    tag_shift      = '0;
    fmt_code       = '0;
    fmt_chans      = '0;
    fmt_rate       = '0;
    fmt_bits       = '0;
    fmt_valid      = 1'b0;
    data_complete  = 1'b0;
    frame_acc      = 0;
    frame_chan     = 0;
    held_low       = '0;
    latched_status = ST_OK;
  endfunction

  function automatic void latch_status(input logic [2:0] code);
    latched_status = code;
    walk_phase     = IN_DONE;
  endfunction

  function automatic void close_fmt();
    if (chunk_len < FMT_MIN_LEN) begin
      latch_status(ST_MISSING);
      return;
    end
    if (fmt_code != FMT_PCM || fmt_bits != FMT_BITS_16 || fmt_chans == 16'd0 ||
        fmt_chans > MAX_CHANS) begin
      fmt_valid = 1'b0;
      latch_status(ST_BAD_FORMAT);
      return;
    end
    fmt_valid = 1'b1;
    if (chunk_len[0]) walk_phase = IN_PAD;
    else walk_phase = IN_HEADER;
    region_count = '0;
  endfunction

  function automatic void open_chunk();
    region_count = '0;
    if (tag_shift == TAG_FMT) begin
      walk_phase = IN_FMT;
      if (chunk_len == 32'd0) close_fmt();
    end else if (tag_shift == TAG_DATA) begin
      if (!fmt_valid) begin
        latch_status(ST_DATA_FIRST);
      end else begin
        walk_phase = IN_DATA;
        frame_acc  = 0;
        frame_chan = 0;
        if (chunk_len == 32'd0) begin
          data_complete = 1'b1;
          walk_phase    = IN_DONE;
        end
      end
    end else if (chunk_len == 32'd0) begin
      walk_phase = IN_HEADER;
    end else begin
      walk_phase = IN_SKIP;
    end
  endfunction

  // Consumes one file byte; returns 1 when it completes a frame.
  function automatic bit absorb_byte(input logic [7:0] b, output logic [15:0] avg);
    logic [31:0] idx;
    logic [15:0] word;
    bit          made;
    idx  = region_count;
    made = 1'b0;
    avg  = '0;
    case (walk_phase)
      IN_RIFF: begin
        tag_shift    = {b, tag_shift[31:8]};
        region_count = idx + 1;
        if (idx == RIFF_TAG_END && tag_shift != TAG_RIFF) begin
          latch_status(ST_NOT_WAVE);
        end else if (idx == RIFF_WAVE_END) begin
          if (tag_shift != TAG_WAVE) begin
            latch_status(ST_NOT_WAVE);
          end else begin
            walk_phase   = IN_HEADER;
            region_count = '0;
          end
        end
      end
      IN_HEADER: begin
        if (idx < HDR_TAG_LEN) tag_shift = {b, tag_shift[31:8]};
        else chunk_len = {b, chunk_len[31:8]};
        region_count = idx + 1;
        if (idx == HDR_LAST) open_chunk();
      end
      IN_FMT: begin
        if (idx == FMT_TAG_LO) fmt_code = {8'h00, b};
        else if (idx == FMT_TAG_HI) fmt_code[15:8] = b;
        else if (idx == FMT_CHAN_LO) fmt_chans = {8'h00, b};
        else if (idx == FMT_CHAN_HI) fmt_chans[15:8] = b;
        else if (idx >= FMT_RATE_LO && idx <= FMT_RATE_HI) fmt_rate = {b, fmt_rate[31:8]};
        else if (idx == FMT_BITS_LO) fmt_bits = {8'h00, b};
        else if (idx == FMT_BITS_HI) fmt_bits[15:8] = b;
        region_count = idx + 1;
        if (region_count == chunk_len) close_fmt();
      end
      IN_DATA: begin
        if (!idx[0]) begin
          held_low = b;
        end else begin
          word       = {b, held_low};
          frame_acc  = frame_acc + $signed(word);
          frame_chan = frame_chan + 1;
          if (frame_chan >= fmt_chans && fmt_chans != 16'd0) begin
            avg        = 16'(frame_acc / int'(fmt_chans));
            frame_acc  = 0;
            frame_chan = 0;
            made       = 1'b1;
          end
        end
        region_count = idx + 1;
        if (region_count == chunk_len) begin
          data_complete = 1'b1;
          walk_phase    = IN_DONE;
        end
      end
      IN_SKIP: begin
        region_count = idx + 1;
        if (region_count == chunk_len) begin
          if (chunk_len[0]) walk_phase = IN_PAD;
          else walk_phase = IN_HEADER;
          region_count = '0;
        end
      end
      IN_PAD: begin
        walk_phase   = IN_HEADER;
        region_count = '0;
      end
      default: ;
    endcase
    return made;
  endfunction

  // Works out the results of one accepted item and queues them.
  function automatic void advance_parser(input logic [7:0] b, input logic bv,
                                         input logic eof);
    wav_output_t r;
    logic [15:0] avg;
    logic [2:0]  code;
    bit          made;
    made = 1'b0;
    avg  = '0;
    if (bv) made = absorb_byte(b, avg);
    if (made) begin
      r.kind   = RK_SAMPLE;
      r.mono   = avg;
      r.status = ST_OK;
      r.rate   = '0;
      r.chans  = '0;
      r.last   = !eof;
      pending_outputs.push_back(r);
    end
    if (eof) begin
      code = latched_status;
      if (code == ST_OK && !(fmt_valid && data_complete)) code = ST_MISSING;
      r.kind   = RK_STATUS;
      r.mono   = '0;
      r.status = code;
      r.rate   = fmt_rate;
      r.chans  = fmt_chans;
      r.last   = 1'b1;
      pending_outputs.push_back(r);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_REPORTS)
      $display("%0t mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic compare_output();
    wav_output_t want;
    if (pending_outputs.size() == 0) begin
      report_mismatch("result kind (no result due)", out_ch.result_kind, '0);
      return;
    end
    want = pending_outputs.pop_front();
    if (out_ch.result_kind !== want.kind)
      report_mismatch("result_kind", out_ch.result_kind, want.kind);
    if (out_ch.mono_sample !== want.mono)
      report_mismatch("mono_sample", out_ch.mono_sample, want.mono);
    if (out_ch.status_code !== want.status)
      report_mismatch("status_code", out_ch.status_code, want.status);
    if (out_ch.rate_hz !== want.rate)
      report_mismatch("rate_hz", out_ch.rate_hz, want.rate);
    if (out_ch.channel_count !== want.chans)
      report_mismatch("channel_count", out_ch.channel_count, want.chans);
    if (out_ch.last_of_run !== want.last)
      report_mismatch("last_of_run", out_ch.last_of_run, want.last);
    if (want.kind == RK_SAMPLE) samples_checked++;
    else statuses_checked++;
  endtask

  // Result side: checks each accepted result and throttles ready.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int mode_left;
    int r;
    bit eager;
    out_ch.ready <= 1'b0;
    stall_left = 0;
    hold_left  = 0;
    mode_left  = 0;
    eager      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) compare_output();
      if (hold_served != hold_requests) begin
        hold_left = LONG_HOLD_CYCLES;
        hold_served++;
      end
      if (mode_left == 0) begin
        eager     = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!eager) begin
          r = $urandom_range(0, 99);
          if (r < 12) stall_left = $urandom_range(1, 3);
          else if (r < 15) stall_left = $urandom_range(4, 12);
          else if (r < 16) stall_left = $urandom_range(25, 60);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles", cycle_count);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Offers one item and returns at the clock edge that accepts it.
  task automatic send_item(input logic [7:0] b, input logic bv, input logic eof);
    int gap;
    gap = sender_eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.byte_value  <= 8'($urandom);
      in_ch.byte_valid  <= 1'($urandom);
      in_ch.end_of_file <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.byte_value  <= b;
    in_ch.byte_valid  <= bv;
    in_ch.end_of_file <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_parser(b, bv, eof);
    items_sent++;
  endtask

  // Sends the byte image, with stray items that carry no byte, then ends the file.
  task automatic send_file(input bit eof_on_byte);
    int n;
    n = wav_bytes.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(wav_bytes[i], 1'b1, eof_on_byte && i == n - 1);
    end
    if (!eof_on_byte || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
    files_sent++;
    wav_bytes.delete();
  endtask

  function automatic void put_u16(input logic [15:0] v);
    wav_bytes.push_back(v[7:0]);
    wav_bytes.push_back(v[15:8]);
  endfunction

  function automatic void put_u32(input logic [31:0] v);
    put_u16(v[15:0]);
    put_u16(v[31:16]);
  endfunction

  function automatic void put_wave_header();
    put_u32(TAG_RIFF);
    put_u32($urandom);
    put_u32(TAG_WAVE);
  endfunction

  function automatic void put_fmt(input logic [31:0] len, input logic [15:0] code,
                                  input logic [15:0] chans, input logic [31:0] rate,
                                  input logic [15:0] bits);
    logic [7:0] body [16];
    body[0]  = code[7:0];
    body[1]  = code[15:8];
    body[2]  = chans[7:0];
    body[3]  = chans[15:8];
    body[4]  = rate[7:0];
    body[5]  = rate[15:8];
    body[6]  = rate[23:16];
    body[7]  = rate[31:24];
    for (int k = 8; k < 14; k++) body[k] = 8'($urandom);
    body[14] = bits[7:0];
    body[15] = bits[15:8];
    put_u32(TAG_FMT);
    put_u32(len);
    for (int k = 0; k < len; k++) wav_bytes.push_back(k < 16 ? body[k] : 8'($urandom));
    if (len[0]) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void put_skip(input logic [31:0] len);
    put_u32($urandom);
    put_u32(len);
    for (int k = 0; k < len; k++) wav_bytes.push_back(8'($urandom));
    if (len[0]) wav_bytes.push_back(8'($urandom));
  endfunction

  // PCM words leaning toward full scale and tiny values.
  function automatic logic [15:0] pick_pcm();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 4)) - 16'd2;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void put_data(input logic [31:0] len);
    put_u32(TAG_DATA);
    put_u32(len);
    for (int k = 0; k + 1 < len; k += 2) put_u16(pick_pcm());
    if (len[0]) wav_bytes.push_back(8'($urandom));
  endfunction

  task automatic test_reference_file();
    // Stereo frames: both full-scale ends, rounding of -1/2 and -3/2
    // toward zero, and opposite extremes cancelling.
    logic [15:0] pcm [12] = '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                              16'hffff, 16'h0000, 16'hfffd, 16'h0000,
                              16'h7fff, 16'h8000, 16'h0005, 16'h0002};
    put_u32(TAG_RIFF);
    put_u32(32'd64);
    put_u32(TAG_WAVE);
    put_skip(32'd3);
    put_fmt(32'd16, FMT_PCM, 16'd2, 32'd44100, FMT_BITS_16);
    put_u32(TAG_DATA);
    put_u32(32'd24);
    foreach (pcm[k]) put_u16(pcm[k]);
    send_file(1'b1);
  endtask

  task automatic test_bad_magic();
    put_u32(TAG_RIFF ^ 32'h0100_0000);
    put_u32($urandom);
    put_u32(TAG_WAVE);
    put_data(32'd4);
    send_file(1'b0);
    put_u32(TAG_RIFF);
    put_u32(32'd36);
    put_u32(TAG_WAVE ^ 32'h8000_0000);
    put_fmt(32'd16, FMT_PCM, 16'd1, 32'd8000, FMT_BITS_16);
    send_file(1'b1);
    wav_bytes.push_back(8'h52);
    wav_bytes.push_back(8'h49);
    send_file(1'b0);
  endtask

  task automatic test_fmt_errors();
    for (int c = 0; c < 6; c++) begin
      put_wave_header();
      case (c)
        0: put_fmt(32'd15, FMT_PCM, 16'd2, 32'd22050, FMT_BITS_16);
        1: put_fmt(32'd0, FMT_PCM, 16'd2, 32'd22050, FMT_BITS_16);
        2: put_fmt(32'd16, 16'd3, 16'd2, 32'd48000, FMT_BITS_16);
        3: put_fmt(32'd16, FMT_PCM, 16'd2, 32'd48000, 16'd8);
        4: put_fmt(32'd16, FMT_PCM, 16'd0, 32'hffff_ffff, FMT_BITS_16);
        default: put_fmt(32'd16, FMT_PCM, 16'(MAX_CHANS + 1), 32'd96000, FMT_BITS_16);
      endcase
      send_file(c[0]);
    end
  endtask

  task automatic test_data_before_fmt();
    put_wave_header();
    put_data(32'd4);
    put_fmt(32'd16, FMT_PCM, 16'd1, 32'd16000, FMT_BITS_16);
    send_file(1'b0);
  endtask

  task automatic test_frame_edges();
    // Odd-length fmt with its pad byte, then a second fmt that widens to the
    // channel limit; the data ends in a partial frame and trailing bytes follow.
    put_wave_header();
    put_fmt(32'd17, FMT_PCM, 16'd1, 32'd11025, FMT_BITS_16);
    put_fmt(32'd18, FMT_PCM, 16'(MAX_CHANS), 32'd192000, FMT_BITS_16);
    put_data(32'(MAX_CHANS * 4 + 5));
    repeat (4) wav_bytes.push_back(8'($urandom));
    send_file(1'b0);
    // File cut short inside its data chunk.
    put_wave_header();
    put_fmt(32'd16, FMT_PCM, 16'd2, 32'd32000, FMT_BITS_16);
    put_data(32'd40);
    repeat (30) void'(wav_bytes.pop_back());
    send_file(1'b1);
    // Empty data chunk, then a file with no bytes at all.
    put_wave_header();
    put_fmt(32'd16, FMT_PCM, 16'd1, 32'd1, FMT_BITS_16);
    put_data(32'd0);
    send_file(1'b0);
    send_file(1'b0);
  endtask

  task automatic test_output_backpressure();
    // The sink stops for a long stretch while bytes keep coming, so the
    // block has to hold off its input.
    hold_requests++;
    sender_eager = 1'b1;
    put_wave_header();
    put_fmt(32'd16, FMT_PCM, 16'd1, 32'd48000, FMT_BITS_16);
    put_data(32'd48);
    send_file(1'b1);
    sender_eager = 1'b0;
  endtask

  task automatic run_random_file();
    int          kind;
    int          frames;
    int          extra;
    int          cut;
    logic [15:0] chans;
    logic [15:0] code;
    logic [15:0] bits;
    logic [31:0] flen;
    logic [31:0] dlen;
    kind  = $urandom_range(0, 99);
    code  = FMT_PCM;
    bits  = FMT_BITS_16;
    chans = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 2))
                                        : 16'($urandom_range(1, MAX_CHANS));
    case ($urandom_range(0, 6))
      3: flen = 32'd17;
      4: flen = 32'd18;
      5: flen = 32'd20;
      6: flen = 32'd24;
      default: flen = FMT_MIN_LEN;
    endcase
    sender_eager = ($urandom_range(0, 3) == 0);
    if (kind < 4) begin
      repeat ($urandom_range(0, 16)) wav_bytes.push_back(8'($urandom));
    end else begin
      put_wave_header();
      if (kind < 10) wav_bytes[$urandom_range(0, 11)] ^= 8'($urandom_range(1, 255));
      repeat ($urandom_range(0, 2)) put_skip($urandom_range(0, 9));
      if (kind >= 10 && kind < 16) put_data($urandom_range(0, 8));
      if (kind >= 16 && kind < 28) begin
        case ($urandom_range(0, 4))
          0: begin
            code = 16'($urandom);
            if (code == FMT_PCM) code = 16'd3;
          end
          1: begin
            bits = 16'($urandom);
            if (bits == FMT_BITS_16) bits = 16'd8;
          end
          2: chans = 16'd0;
          3: chans = 16'($urandom_range(MAX_CHANS + 1, 65535));
          default: flen = $urandom_range(0, 15);
        endcase
      end
      if (kind >= 28 && kind < 36)
        put_fmt(flen, FMT_PCM, 16'($urandom_range(1, MAX_CHANS)), $urandom, FMT_BITS_16);
      put_fmt(flen, code, chans, $urandom, bits);
      if ($urandom_range(0, 3) == 0) put_skip($urandom_range(1, 7));
      frames = $urandom_range(0, 4);
      extra  = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      if (chans <= MAX_CHANS) dlen = 32'(frames * chans * 2 + extra);
      else dlen = $urandom_range(0, 12);
      put_data(dlen);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 6)) wav_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, wav_bytes.size());
        repeat (cut) void'(wav_bytes.pop_back());
      end
      if ($urandom_range(0, 19) == 0 && wav_bytes.size() > 0)
        wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] ^= 8'($urandom_range(1, 255));
    end
    send_file(1'($urandom_range(0, 1)));
    sender_eager = 1'b0;
  endtask

  task automatic test_random_files();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) run_random_file();
  endtask

  initial begin : stimulus
    error_count      = 0;
    items_sent       = 0;
    files_sent       = 0;
    samples_checked  = 0;
    statuses_checked = 0;
    hold_requests    = 0;
    hold_served      = 0;
    sender_eager     = 1'b0;
    clear_parser();
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.byte_value  <= 8'h00;
    in_ch.byte_valid  <= 1'b0;
    in_ch.end_of_file <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reference_file();
    test_bad_magic();
    test_fmt_errors();
    test_data_before_fmt();
    test_frame_edges();
    test_output_backpressure();
    test_random_files();

    in_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d files as %0d items; checked %0d mono samples and %0d statuses",
             files_sent, items_sent, samples_checked, statuses_checked);
    $display("Mismatches: %0d, results still due: %0d", error_count,
             pending_outputs.size());
    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/wpd_pkg.sv
src/wpd_in_if.sv
src/wpd_out_if.sv
src/wpd_div.sv
src/wpd_dpath.sv
src/wpd_ctrl.sv
src/wav_pcm16_parse_downmix.sv
test/wav_pcm16_parse_downmix_test.sv
